FILE: rtl/core/shs_pkg.sv
package shs_pkg;

  // Working variables of one compression, a in the top bits.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  localparam work_t SHA_IV = '{
    a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
    e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/shs_round.sv
module shs_round
  import shs_pkg::*;
(
  input  work_t       cur,
  input  logic [5:0]  rnd,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w9,
  input  logic [31:0] w14,
  output work_t       nxt,
  output logic [31:0] w_new
);

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, g0, g1;

  always_comb begin
    big_s1 = {cur.e[5:0], cur.e[31:6]} ^ {cur.e[10:0], cur.e[31:11]} ^
             {cur.e[24:0], cur.e[31:25]};
    big_s0 = {cur.a[1:0], cur.a[31:2]} ^ {cur.a[12:0], cur.a[31:13]} ^
             {cur.a[21:0], cur.a[31:22]};
    ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
    maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t1  = cur.h + big_s1 + ch + round_k(rnd) + w0;
    t2  = big_s0 + maj;

    nxt.a = t1 + t2;
    nxt.b = cur.a;
    nxt.c = cur.b;
    nxt.d = cur.c;
    nxt.e = cur.d + t1;
    nxt.f = cur.e;
    nxt.g = cur.f;
    nxt.h = cur.g;

    // message schedule: W[t+16] from the window
    g0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    g1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
    w_new = w0 + g0 + w9 + g1;
  end

endmodule

FILE: rtl/core/sha256_stream_hasher_unit.sv
// SHA-256 over a byte stream.
// Input channel (in_*): one transfer carries at most one message byte.
//   in_tdata = message byte, in_tuser = byte present, in_tlast = end of message.
//   A transfer with in_tuser low and in_tlast low is an idle item.
// Output channel (out_*): after end of message, four transfers carry the
//   digest, 64 bits each, big-endian, word 0 first; out_tuser is the word
//   index and out_tlast marks the fourth word.
// Timing: the 64th byte of a block starts the compression: 64 rounds on
//   one shared round unit, one round per cycle, then a fold into the
//   chaining words (in_tready low throughout).
//   End of message pads one byte per cycle (9 to 72 bytes), with one or two
//   compressions among them, then presents the four digest words.
// The input is not ready from end of message until the fourth digest word
//   transfers. A stalled receiver just holds the digest words in place.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
//   the byte count; the block then waits for the first byte. After the last
//   digest word it returns to that same state for the next message.
module sha256_stream_hasher_unit
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // padding phases
  localparam logic [1:0] PH_MARK = 2'd0;  // the 0x80 byte
  localparam logic [1:0] PH_ZERO = 2'd1;  // zeros up to byte 56
  localparam logic [1:0] PH_LEN  = 2'd2;  // eight length bytes
  localparam logic [1:0] PH_DONE = 2'd3;  // all padding pushed

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  lcnt_r, lcnt_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  work_t       chain_r, chain_nxt;
  work_t       work_r, work_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] w_r [16];

  logic        in_fire, out_fire;
  logic        push_en;
  logic [7:0]  push_byte;
  logic        w_shift;
  logic [31:0] w_in;
  work_t       round_out;
  logic [31:0] sched_word;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_tvalid & out_tready;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 2'd3);

  always_comb begin
    unique case (oidx_r)
      2'd0: out_tdata = {chain_r.a, chain_r.b};
      2'd1: out_tdata = {chain_r.c, chain_r.d};
      2'd2: out_tdata = {chain_r.e, chain_r.f};
      2'd3: out_tdata = {chain_r.g, chain_r.h};
    endcase
  end

  shs_round u_round (
    .cur   (work_r),
    .rnd   (rnd_r),
    .w0    (w_r[0]),
    .w1    (w_r[1]),
    .w9    (w_r[9]),
    .w14   (w_r[14]),
    .nxt   (round_out),
    .w_new (sched_word)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    fin_nxt   = fin_r;
    phase_nxt = phase_r;
    lcnt_nxt  = lcnt_r;
    oidx_nxt  = oidx_r;
    rnd_nxt   = rnd_r;
    chain_nxt = chain_r;
    work_nxt  = work_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    push_en   = 1'b0;
    push_byte = 8'h00;
    w_shift   = 1'b0;
    w_in      = sched_word;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          push_en   = in_tuser;
          push_byte = in_tdata;
          if (in_tuser) begin
            total_nxt = total_r + 61'd1;
          end
          if (in_tlast) begin
            fin_nxt   = 1'b1;
            phase_nxt = PH_MARK;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        unique case (phase_r)
          PH_MARK: begin
            push_byte = 8'h80;
            len_nxt   = {total_r, 3'b000};
            phase_nxt = (fill_r == 6'd55) ? PH_LEN : PH_ZERO;
          end
          PH_ZERO: begin
            push_byte = 8'h00;
            if (fill_r == 6'd55) begin
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            push_byte = len_r[63:56];
            len_nxt   = {len_r[55:0], 8'h00};
            lcnt_nxt  = lcnt_r + 3'd1;
            if (lcnt_r == 3'd7) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            push_en = 1'b0;  // not reached: the last length byte ends a block
          end
        endcase
      end
      ST_ROUND: begin
        work_nxt = round_out;
        w_shift  = 1'b1;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt.a = chain_r.a + work_r.a;
        chain_nxt.b = chain_r.b + work_r.b;
        chain_nxt.c = chain_r.c + work_r.c;
        chain_nxt.d = chain_r.d + work_r.d;
        chain_nxt.e = chain_r.e + work_r.e;
        chain_nxt.f = chain_r.f + work_r.f;
        chain_nxt.g = chain_r.g + work_r.g;
        chain_nxt.h = chain_r.h + work_r.h;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            chain_nxt = SHA_IV;
            fill_nxt  = 6'd0;
            total_nxt = 61'd0;
            fin_nxt   = 1'b0;
            phase_nxt = PH_MARK;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte into the block: four bytes make a schedule word, 64 start a compression
    if (push_en) begin
      acc_nxt  = {acc_r[15:0], push_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == 2'b11) begin
        w_shift = 1'b1;
        w_in    = {acc_r, push_byte};
      end
      if (fill_r == 6'd63) begin
        work_nxt  = chain_r;
        rnd_nxt   = 6'd0;
        state_nxt = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= 6'd0;
      total_r <= 61'd0;
      fin_r   <= 1'b0;
      phase_r <= PH_MARK;
      lcnt_r  <= 3'd0;
      oidx_r  <= 2'd0;
      rnd_r   <= 6'd0;
      chain_r <= SHA_IV;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      fin_r   <= fin_nxt;
      phase_r <= phase_nxt;
      lcnt_r  <= lcnt_nxt;
      oidx_r  <= oidx_nxt;
      rnd_r   <= rnd_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    acc_r  <= acc_nxt;
    len_r  <= len_nxt;
    if (w_shift) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_in;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // Half clock period, reset length, drain after the last digest, run limit.
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MIN_ITEMS    = 150;
  localparam int MIN_MESSAGES = 6;

  // Well-known digests, typed in for the directed rows.
  localparam logic [255:0] DIGEST_EMPTY =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DIGEST_ABC =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] HASH_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One digest word as it should leave the output channel.
  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_xfer_t;

  // One row of the directed table; golden rows carry a typed-in digest.
  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         has_golden;
    logic [255:0] golden;
  } stim_row_t;

  localparam int NUM_ROWS = 16;

  // DUT ports; the inputs are known from time zero.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Hasher shadow state.
  logic [31:0] hash_state [0:7];
  logic [7:0]  blk_bytes [0:63];
  int unsigned blk_fill;
  logic [60:0] msg_bytes;

  digest_xfer_t pending_words [$];
  stim_row_t    directed_rows [NUM_ROWS];

  int  err_count   = 0;
  int  cycle_count = 0;
  // Set for whole messages: neither side idles while it is high.
  bit  steady      = 1'b0;

  sha256_stream_hasher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit; a hang in either channel ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sha256_stream_hasher_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void hasher_clear();
    for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
    blk_fill  = 0;
    msg_bytes = '0;
  endfunction

  // 64-round compression of the full block into the chaining words.
  function automatic void compress_block();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  // Advances the shadow hasher by one input transfer. Returns 1 with the
  // full digest when the transfer ends a message.
  function automatic bit sha_step(input logic [7:0] data, input logic present,
                                  input logic eom, output logic [255:0] digest);
    logic [63:0] bit_len;
    digest = '0;
    if (present) begin
      absorb_byte(data);
      msg_bytes = msg_bytes + 61'd1;
    end
    if (!eom) return 1'b0;
    // Padding: 0x80, zeros to byte 56, then 64-bit big-endian bit count.
    bit_len = {msg_bytes, 3'b000};
    absorb_byte(8'h80);
    while (blk_fill != 56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
    digest = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
              hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    hasher_clear();
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  // Offers one input item after a random gap and waits for its transfer.
  // valid stays high across back-to-back items (gap 0).
  task automatic send_item(input logic [7:0] data, input logic present,
                           input logic eom, input logic use_golden,
                           input logic [255:0] golden);
    int gap;
    logic [255:0] digest;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sha_step(data, present, eom, digest)) begin
      if (use_golden) digest = golden;
      for (int i = 0; i < 4; i++)
        pending_words.push_back('{word: digest[255 - 64*i -: 64],
                                  index: 2'(i), last: (i == 3)});
    end
  endtask

  // Stimulus: directed table, then random messages.
  initial begin
    int len;
    int msg_count;
    int item_count;
    bit tail_eom;
    hasher_clear();
    directed_rows = '{
      // data    pres  eom   gold  digest
      '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},         // idle right after reset
      '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},   // empty message
      '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},         // idle, data ignored
      '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},   // finish only, data ignored
      '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},         // "abc", end on last byte
      '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
      '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},         // one zero byte
      '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},         // one all-ones byte
      '{8'h55, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'haa, 1'b0, 1'b0, 1'b0, 256'h0},         // idle inside a message
      '{8'haa, 1'b0, 1'b1, 1'b0, 256'h0},         // finish without a byte
      '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},         // "abc", separate finish
      '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].data, directed_rows[r].present, directed_rows[r].eom,
                directed_rows[r].has_golden, directed_rows[r].golden);

    // Random messages: mostly short, some straddling the 55/56 padding
    // split and the 64-byte block edge, a few spanning two blocks.
    msg_count  = 0;
    item_count = NUM_ROWS;
    while (item_count < MIN_ITEMS || msg_count < MIN_MESSAGES) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 15))
        11:      len = $urandom_range(55, 57);
        12:      len = $urandom_range(63, 65);
        13:      len = $urandom_range(119, 121);
        14:      len = $urandom_range(8, 54);
        default: len = $urandom_range(0, 6);
      endcase
      tail_eom = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int b = 0; b < len; b++) begin
        // Occasional idle transfer as noise.
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
          item_count++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, tail_eom && (b == len - 1),
                  1'b0, '0);
        item_count++;
      end
      if (!tail_eom) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        item_count++;
      end
      msg_count++;
    end
    in_tvalid <= 1'b0;
    steady    = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_words.size() == 0)
      $display("** sha256_stream_hasher_unit: PASSED **");
    else
      $display("** sha256_stream_hasher_unit: FAILED **");
    $finish;
  end

  // Digest receiver: random stall before each transfer, then check
  // against the oldest expected word.
  initial begin
    digest_xfer_t want;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (pending_words.size() == 0) begin
        $error("digest_word: no transfer expected, got %h", out_tdata);
        err_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_tdata !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, out_tdata);
          err_count++;
        end
        if (out_tuser !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, out_tuser);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, out_tlast);
          err_count++;
        end
      end
    end
  end

endmodule

FILE: sim.f
rtl/core/shs_pkg.sv
rtl/core/shs_round.sv
rtl/core/sha256_stream_hasher_unit.sv
tb/tb.sv
